/* sv/psc_pkg.sv */
// Shared types and constants of the particle/segment collision response core.
// Holds the beat structs, the register map, and the cell link formats of the
// division and square-root chains. No dependencies.
package psc_pkg;

  localparam int PADDR_W   = 5;
  localparam int PSC_TAG_W = 320;
  localparam int DIV_DW    = 62;
  localparam int DIV_QW    = 48;
  localparam int SQRT_W    = 64;
  localparam int SQRT_N    = 32;

  localparam logic [SQRT_W-1:0] SQRT_TOP_BIT = SQRT_W'(1) << (SQRT_W - 2);

  localparam logic [2:0] REG_SEG_AX    = 3'd0;
  localparam logic [2:0] REG_SEG_AY    = 3'd1;
  localparam logic [2:0] REG_SEG_BX    = 3'd2;
  localparam logic [2:0] REG_SEG_BY    = 3'd3;
  localparam logic [2:0] REG_RADIUS    = 3'd4;
  localparam logic [2:0] REG_TIME_STEP = 3'd5;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } psc_in_t;

  typedef struct packed {
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               hit_body;
    logic               hit_end_a;
    logic               hit_end_b;
  } psc_out_t;

  typedef struct packed {
    logic [DIV_DW-1:0] d;
    logic [DIV_DW-1:0] rem;
    logic [DIV_QW-1:0] low;
    logic [DIV_QW-1:0] q;
  } psc_div_t;

  typedef struct packed {
    logic [SQRT_W-1:0] rem;
    logic [SQRT_W-1:0] root;
    logic [SQRT_W-1:0] bpos;
  } psc_sqrt_t;

endpackage

/* sv/psc_div_cell.sv */
// One restoring division step: shift in one dividend bit, compare, subtract.
// Depends on psc_pkg for the link format.
module psc_div_cell (
  input  logic               clk_i,
  input  logic               en_i,
  input  psc_pkg::psc_div_t  div_i,
  output psc_pkg::psc_div_t  div_o
);
  import psc_pkg::*;

  logic [DIV_DW:0]   part;
  logic [DIV_DW:0]   diff;
  logic              ge;
  psc_div_t          div_d;
  psc_div_t          div_q;

  always_comb begin
    part      = {div_i.rem, div_i.low[DIV_QW-1]};
    diff      = part - {1'b0, div_i.d};
    ge        = part >= {1'b0, div_i.d};
    div_d.d   = div_i.d;
    div_d.rem = ge ? diff[DIV_DW-1:0] : part[DIV_DW-1:0];
    div_d.low = {div_i.low[DIV_QW-2:0], 1'b0};
    div_d.q   = {div_i.q[DIV_QW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

/* sv/psc_div_chain.sv */
// Row of division cells giving one quotient bit per cell, with valid and tag
// carried alongside. Depends on psc_pkg and psc_div_cell.
module psc_div_chain (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [psc_pkg::PSC_TAG_W-1:0]   tag_i,
  input  psc_pkg::psc_div_t               div_i,
  output logic                            valid_o,
  output logic [psc_pkg::PSC_TAG_W-1:0]   tag_o,
  output logic [psc_pkg::DIV_QW-1:0]      quot_o
);
  import psc_pkg::*;

  psc_div_t             link [DIV_QW+1];
  logic [DIV_QW-1:0]    valid_q;
  logic [PSC_TAG_W-1:0] tag_q [DIV_QW];

  assign link[0] = div_i;

  for (genvar i = 0; i < DIV_QW; i++) begin : g_cell
    psc_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .div_i (link[i]),
      .div_o (link[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[DIV_QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      for (int k = 1; k < DIV_QW; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  assign valid_o = valid_q[DIV_QW-1];
  assign tag_o   = tag_q[DIV_QW-1];
  assign quot_o  = link[DIV_QW].q;

endmodule

/* sv/psc_sqrt_cell.sv */
// One digit-by-digit integer square root step on a 64-bit radicand.
// Depends on psc_pkg for the link format.
module psc_sqrt_cell (
  input  logic               clk_i,
  input  logic               en_i,
  input  psc_pkg::psc_sqrt_t sq_i,
  output psc_pkg::psc_sqrt_t sq_o
);
  import psc_pkg::*;

  logic [SQRT_W-1:0] trial;
  logic              ge;
  psc_sqrt_t         sq_d;
  psc_sqrt_t         sq_q;

  always_comb begin
    trial     = sq_i.root + sq_i.bpos;
    ge        = sq_i.rem >= trial;
    sq_d.rem  = ge ? sq_i.rem - trial : sq_i.rem;
    sq_d.root = ge ? (sq_i.root >> 1) + sq_i.bpos : sq_i.root >> 1;
    sq_d.bpos = sq_i.bpos >> 2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

/* sv/psc_sqrt_chain.sv */
// Row of square-root cells, one result bit per cell, with valid and tag
// carried alongside. Depends on psc_pkg and psc_sqrt_cell.
module psc_sqrt_chain (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [psc_pkg::PSC_TAG_W-1:0]   tag_i,
  input  logic [psc_pkg::SQRT_W-1:0]      rad_i,
  output logic                            valid_o,
  output logic [psc_pkg::PSC_TAG_W-1:0]   tag_o,
  output logic [31:0]                     root_o
);
  import psc_pkg::*;

  psc_sqrt_t            link [SQRT_N+1];
  logic [SQRT_N-1:0]    valid_q;
  logic [PSC_TAG_W-1:0] tag_q [SQRT_N];

  assign link[0] = '{rem: rad_i, root: '0, bpos: SQRT_TOP_BIT};

  for (genvar i = 0; i < SQRT_N; i++) begin : g_cell
    psc_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .sq_i  (link[i]),
      .sq_o  (link[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[SQRT_N-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      for (int k = 1; k < SQRT_N; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  assign valid_o = valid_q[SQRT_N-1];
  assign tag_o   = tag_q[SQRT_N-1];
  assign root_o  = link[SQRT_N].root[31:0];

endmodule

/* sv/particle_segment_collision_response_core.sv */
// Particle against wall segment collision response, fixed-point Q16.16.
// Depends on psc_pkg, psc_div_chain and psc_sqrt_chain.
//
// One particle beat enters per cycle and one result beat leaves per cycle
// unless stalled. Beats cross three rows of 48-cell division chains (projection
// fraction, unit vector, push over time step) and two 32-cell square-root chains.
// The whole pipeline advances only while the output register is empty or taken,
// so a held result stalls the input. Segment, radius and time step are read live
// from the registers and must be written only while no beat is in flight.
module particle_segment_collision_response_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  psc_pkg::psc_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output psc_pkg::psc_out_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psc_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import psc_pkg::*;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [30:0] acx;
    logic signed [30:0] acy;
    logic signed [30:0] an_x;
    logic signed [30:0] an_y;
    logic signed [30:0] bn_x;
    logic signed [30:0] bn_y;
    logic               on_seg;
  } tag1_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] v0x;
    logic signed [31:0] v0y;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic               on_seg;
  } tag2_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        e0;
    logic [30:0]        e1;
    logic               p0;
    logic               p1;
    logic               s0x;
    logic               s0y;
    logic               s1x;
    logic               s1y;
    logic               on_seg;
  } tag3_t;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic [19:0] hi;
    hi = v[50:31];
    if (hi == '0 || hi == '1) begin
      return v[31:0];
    end else if (v[50]) begin
      return {1'b1, 31'b0};
    end else begin
      return {1'b0, {31{1'b1}}};
    end
  endfunction

  function automatic logic signed [30:0] qdiff(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32:2];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [50:0] term(input logic p, input logic s,
                                              input logic [DIV_QW-1:0] q);
    logic signed [50:0] m;
    m = $signed({3'b000, q});
    if (!p) begin
      return '0;
    end
    return s ? -m : m;
  endfunction

  // configuration registers
  logic signed [31:0] seg_ax_q, seg_ay_q, seg_bx_q, seg_by_q;
  logic [30:0]        radius_q;
  logic [16:0]        time_step_q;
  logic [2:0]         reg_idx;
  logic               reg_wr;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign reg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_ax_q    <= '0;
      seg_ay_q    <= '0;
      seg_bx_q    <= 32'sd65536;
      seg_by_q    <= '0;
      radius_q    <= 31'd65536;
      time_step_q <= 17'd1092;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_SEG_AX:    seg_ax_q    <= pwdata;
        REG_SEG_AY:    seg_ay_q    <= pwdata;
        REG_SEG_BX:    seg_bx_q    <= pwdata;
        REG_SEG_BY:    seg_by_q    <= pwdata;
        REG_RADIUS:    radius_q    <= pwdata[30:0];
        REG_TIME_STEP: time_step_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SEG_AX:    prdata = seg_ax_q;
      REG_SEG_AY:    prdata = seg_ay_q;
      REG_SEG_BX:    prdata = seg_bx_q;
      REG_SEG_BY:    prdata = seg_by_q;
      REG_RADIUS:    prdata = {1'b0, radius_q};
      REG_TIME_STEP: prdata = {15'b0, time_step_q};
      default:       prdata = '0;
    endcase
  end

  logic signed [30:0] abx, aby;
  logic [16:0]        dt_div;

  assign abx    = qdiff(seg_bx_q, seg_ax_q);
  assign aby    = qdiff(seg_by_q, seg_ay_q);
  assign dt_div = (time_step_q == '0) ? 17'd1 : time_step_q;

  logic adv;
  logic out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // predicted position product
  logic               s1_v_q;
  logic signed [31:0] s1_px_q, s1_py_q, s1_vx_q, s1_vy_q;
  logic signed [49:0] s1_mx_q, s1_my_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_px_q <= in_data_i.pos_x;
      s1_py_q <= in_data_i.pos_y;
      s1_vx_q <= in_data_i.vel_x;
      s1_vy_q <= in_data_i.vel_y;
      s1_mx_q <= $signed(in_data_i.vel_x) * $signed({1'b0, time_step_q});
      s1_my_q <= $signed(in_data_i.vel_y) * $signed({1'b0, time_step_q});
    end
  end

  // predicted position and differences
  logic signed [33:0] nx_sum, ny_sum;
  logic signed [31:0] nx, ny;
  logic               s2_v_q;
  tag1_t              s2_q;

  assign nx_sum = $signed({{2{s1_px_q[31]}}, s1_px_q}) + $signed(s1_mx_q[49:16]);
  assign ny_sum = $signed({{2{s1_py_q[31]}}, s1_py_q}) + $signed(s1_my_q[49:16]);
  assign nx     = sat32($signed({{17{nx_sum[33]}}, nx_sum}));
  assign ny     = sat32($signed({{17{ny_sum[33]}}, ny_sum}));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q.vel_x  <= s1_vx_q;
      s2_q.vel_y  <= s1_vy_q;
      s2_q.acx    <= qdiff(nx, seg_ax_q);
      s2_q.acy    <= qdiff(ny, seg_ay_q);
      s2_q.an_x   <= qdiff(seg_ax_q, nx);
      s2_q.an_y   <= qdiff(seg_ay_q, ny);
      s2_q.bn_x   <= qdiff(seg_bx_q, nx);
      s2_q.bn_y   <= qdiff(seg_by_q, ny);
      s2_q.on_seg <= 1'b0;
    end
  end

  // dot and length products
  logic               s3_v_q;
  tag1_t              s3_q;
  logic signed [61:0] s3_pdx_q, s3_pdy_q, s3_plx_q, s3_ply_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q     <= s2_q;
      s3_pdx_q <= abx * s2_q.acx;
      s3_pdy_q <= aby * s2_q.acy;
      s3_plx_q <= abx * abx;
      s3_ply_q <= aby * aby;
    end
  end

  // projection range test
  logic signed [62:0] dot, len2;
  logic               s4_v_q;
  tag1_t              s4_d;
  tag1_t              s4_q;
  logic signed [62:0] s4_dot_q, s4_len2_q;

  assign dot  = $signed({s3_pdx_q[61], s3_pdx_q}) + $signed({s3_pdy_q[61], s3_pdy_q});
  assign len2 = $signed({s3_plx_q[61], s3_plx_q}) + $signed({s3_ply_q[61], s3_ply_q});

  always_comb begin
    s4_d        = s3_q;
    s4_d.on_seg = (len2 != '0) && !dot[62] && (dot <= len2);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_q        <= s4_d;
      s4_dot_q    <= dot;
      s4_len2_q   <= len2;
    end
  end

  // projection fraction t = dot * 2^30 / len2
  psc_div_t             fr_div;
  logic                 fr_v;
  logic [PSC_TAG_W-1:0] fr_tag;
  logic [DIV_QW-1:0]    fr_q;
  tag1_t                fr_t;

  assign fr_div = '{d: s4_len2_q[DIV_DW-1:0], rem: {18'b0, s4_dot_q[61:18]},
                    low: {s4_dot_q[17:0], 30'b0}, q: '0};

  psc_div_chain u_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s4_v_q),
    .tag_i   ({{(PSC_TAG_W-$bits(tag1_t)){1'b0}}, s4_q}),
    .div_i   (fr_div),
    .valid_o (fr_v),
    .tag_o   (fr_tag),
    .quot_o  (fr_q)
  );

  assign fr_t = fr_tag[$bits(tag1_t)-1:0];

  // foot of projection
  logic               s5_v_q;
  tag1_t              s5_q;
  logic signed [62:0] s5_pax_q, s5_pay_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_q     <= fr_t;
      s5_pax_q <= abx * $signed({1'b0, fr_q[30:0]});
      s5_pay_q <= aby * $signed({1'b0, fr_q[30:0]});
    end
  end

  // push vectors
  logic signed [32:0] cpx, cpy;
  logic               s6_v_q;
  tag2_t              s6_q;

  assign cpx = $signed(s5_pax_q[62:30]) - $signed({{2{s5_q.acx[30]}}, s5_q.acx});
  assign cpy = $signed(s5_pay_q[62:30]) - $signed({{2{s5_q.acy[30]}}, s5_q.acy});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_q.vel_x  <= s5_q.vel_x;
      s6_q.vel_y  <= s5_q.vel_y;
      s6_q.v0x    <= s5_q.on_seg ? cpx[31:0] : {s5_q.an_x[30], s5_q.an_x};
      s6_q.v0y    <= s5_q.on_seg ? cpy[31:0] : {s5_q.an_y[30], s5_q.an_y};
      s6_q.v1x    <= {s5_q.bn_x[30], s5_q.bn_x};
      s6_q.v1y    <= {s5_q.bn_y[30], s5_q.bn_y};
      s6_q.on_seg <= s5_q.on_seg;
    end
  end

  // squares
  logic               s7_v_q;
  tag2_t              s7_q;
  logic signed [63:0] s7_q0x_q, s7_q0y_q, s7_q1x_q, s7_q1y_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_q     <= s6_q;
      s7_q0x_q <= s6_q.v0x * s6_q.v0x;
      s7_q0y_q <= s6_q.v0y * s6_q.v0y;
      s7_q1x_q <= s6_q.v1x * s6_q.v1x;
      s7_q1y_q <= s6_q.v1y * s6_q.v1y;
    end
  end

  // squared distances
  logic              s8_v_q;
  tag2_t             s8_q;
  logic [SQRT_W-1:0] s8_r0_q, s8_r1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_q    <= s7_q;
      s8_r0_q <= SQRT_W'(s7_q0x_q) + SQRT_W'(s7_q0y_q);
      s8_r1_q <= SQRT_W'(s7_q1x_q) + SQRT_W'(s7_q1y_q);
    end
  end

  logic                 sq_v;
  logic [PSC_TAG_W-1:0] sq_tag;
  logic [31:0]          d0, d1;
  tag2_t                sq_t;

  psc_sqrt_chain u_sqrt0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s8_v_q),
    .tag_i   ({{(PSC_TAG_W-$bits(tag2_t)){1'b0}}, s8_q}),
    .rad_i   (s8_r0_q),
    .valid_o (sq_v),
    .tag_o   (sq_tag),
    .root_o  (d0)
  );

  psc_sqrt_chain u_sqrt1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s8_v_q),
    .tag_i   ('0),
    .rad_i   (s8_r1_q),
    .valid_o (),
    .tag_o   (),
    .root_o  (d1)
  );

  assign sq_t = sq_tag[$bits(tag2_t)-1:0];

  // push test and unit vector setup
  logic [33:0] fd0, fd1;
  logic [31:0] m0x, m0y, m1x, m1y;
  logic        s9_v_q;
  tag3_t       s9_q;
  psc_div_t    s9_u0x_q, s9_u0y_q, s9_u1x_q, s9_u1y_q;

  assign fd0 = {d0, 2'b00};
  assign fd1 = {d1, 2'b00};
  assign m0x = mag32(sq_t.v0x);
  assign m0y = mag32(sq_t.v0y);
  assign m1x = mag32(sq_t.v1x);
  assign m1y = mag32(sq_t.v1y);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s9_q.vel_x  <= sq_t.vel_x;
      s9_q.vel_y  <= sq_t.vel_y;
      s9_q.e0     <= radius_q - fd0[30:0];
      s9_q.e1     <= radius_q - fd1[30:0];
      s9_q.p0     <= (d0 != '0) && (fd0 < {3'b0, radius_q});
      s9_q.p1     <= !sq_t.on_seg && (d1 != '0) && (fd1 < {3'b0, radius_q});
      s9_q.s0x    <= sq_t.v0x[31];
      s9_q.s0y    <= sq_t.v0y[31];
      s9_q.s1x    <= sq_t.v1x[31];
      s9_q.s1y    <= sq_t.v1y[31];
      s9_q.on_seg <= sq_t.on_seg;
      s9_u0x_q    <= '{d: {30'b0, d0}, rem: {48'b0, m0x[31:18]},
                       low: {m0x[17:0], 30'b0}, q: '0};
      s9_u0y_q    <= '{d: {30'b0, d0}, rem: {48'b0, m0y[31:18]},
                       low: {m0y[17:0], 30'b0}, q: '0};
      s9_u1x_q    <= '{d: {30'b0, d1}, rem: {48'b0, m1x[31:18]},
                       low: {m1x[17:0], 30'b0}, q: '0};
      s9_u1y_q    <= '{d: {30'b0, d1}, rem: {48'b0, m1y[31:18]},
                       low: {m1y[17:0], 30'b0}, q: '0};
    end
  end

  logic                 un_v;
  logic [PSC_TAG_W-1:0] un_tag;
  logic [DIV_QW-1:0]    u0x, u0y, u1x, u1y;
  tag3_t                un_t;

  psc_div_chain u_unit0x (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv), .valid_i (s9_v_q),
    .tag_i ({{(PSC_TAG_W-$bits(tag3_t)){1'b0}}, s9_q}), .div_i (s9_u0x_q),
    .valid_o (un_v), .tag_o (un_tag), .quot_o (u0x)
  );

  psc_div_chain u_unit0y (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv), .valid_i (s9_v_q),
    .tag_i ('0), .div_i (s9_u0y_q), .valid_o (), .tag_o (), .quot_o (u0y)
  );

  psc_div_chain u_unit1x (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv), .valid_i (s9_v_q),
    .tag_i ('0), .div_i (s9_u1x_q), .valid_o (), .tag_o (), .quot_o (u1x)
  );

  psc_div_chain u_unit1y (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv), .valid_i (s9_v_q),
    .tag_i ('0), .div_i (s9_u1y_q), .valid_o (), .tag_o (), .quot_o (u1y)
  );

  assign un_t = un_tag[$bits(tag3_t)-1:0];

  // unit vector times penetration
  logic        s10_v_q;
  tag3_t       s10_q;
  logic [61:0] s10_m0x_q, s10_m0y_q, s10_m1x_q, s10_m1y_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s10_q     <= un_t;
      s10_m0x_q <= u0x[30:0] * un_t.e0;
      s10_m0y_q <= u0y[30:0] * un_t.e0;
      s10_m1x_q <= u1x[30:0] * un_t.e1;
      s10_m1y_q <= u1y[30:0] * un_t.e1;
    end
  end

  // divide by the time step
  logic     s11_v_q;
  tag3_t    s11_q;
  psc_div_t s11_k0x_q, s11_k0y_q, s11_k1x_q, s11_k1y_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s11_q     <= s10_q;
      s11_k0x_q <= '{d: {45'b0, dt_div}, rem: '0, low: s10_m0x_q[61:14], q: '0};
      s11_k0y_q <= '{d: {45'b0, dt_div}, rem: '0, low: s10_m0y_q[61:14], q: '0};
      s11_k1x_q <= '{d: {45'b0, dt_div}, rem: '0, low: s10_m1x_q[61:14], q: '0};
      s11_k1y_q <= '{d: {45'b0, dt_div}, rem: '0, low: s10_m1y_q[61:14], q: '0};
    end
  end

  logic                 kd_v;
  logic [PSC_TAG_W-1:0] kd_tag;
  logic [DIV_QW-1:0]    k0x, k0y, k1x, k1y;
  tag3_t                kd_t;

  psc_div_chain u_step0x (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv), .valid_i (s11_v_q),
    .tag_i ({{(PSC_TAG_W-$bits(tag3_t)){1'b0}}, s11_q}), .div_i (s11_k0x_q),
    .valid_o (kd_v), .tag_o (kd_tag), .quot_o (k0x)
  );

  psc_div_chain u_step0y (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv), .valid_i (s11_v_q),
    .tag_i ('0), .div_i (s11_k0y_q), .valid_o (), .tag_o (), .quot_o (k0y)
  );

  psc_div_chain u_step1x (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv), .valid_i (s11_v_q),
    .tag_i ('0), .div_i (s11_k1x_q), .valid_o (), .tag_o (), .quot_o (k1x)
  );

  psc_div_chain u_step1y (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv), .valid_i (s11_v_q),
    .tag_i ('0), .div_i (s11_k1y_q), .valid_o (), .tag_o (), .quot_o (k1y)
  );

  assign kd_t = kd_tag[$bits(tag3_t)-1:0];

  // accumulate, saturate, hold the result beat
  logic signed [50:0] acc_x, acc_y;
  psc_out_t           out_q;

  assign acc_x = $signed({{19{kd_t.vel_x[31]}}, kd_t.vel_x})
               - term(kd_t.p0, kd_t.s0x, k0x) - term(kd_t.p1, kd_t.s1x, k1x);
  assign acc_y = $signed({{19{kd_t.vel_y[31]}}, kd_t.vel_y})
               - term(kd_t.p0, kd_t.s0y, k0y) - term(kd_t.p1, kd_t.s1y, k1y);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.new_vel_x <= sat32(acc_x);
      out_q.new_vel_y <= sat32(acc_y);
      out_q.hit_body  <= kd_t.on_seg & kd_t.p0;
      out_q.hit_end_a <= !kd_t.on_seg & kd_t.p0;
      out_q.hit_end_b <= kd_t.p1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      s6_v_q      <= 1'b0;
      s7_v_q      <= 1'b0;
      s8_v_q      <= 1'b0;
      s9_v_q      <= 1'b0;
      s10_v_q     <= 1'b0;
      s11_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= in_valid_i;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      s5_v_q      <= fr_v;
      s6_v_q      <= s5_v_q;
      s7_v_q      <= s6_v_q;
      s8_v_q      <= s7_v_q;
      s9_v_q      <= sq_v;
      s10_v_q     <= un_v;
      s11_v_q     <= s10_v_q;
      out_valid_q <= kd_v;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sv/psc_checker.sv */
// Port-level checks on the collision response core, bound to its top level.
// Depends on psc_pkg and particle_segment_collision_response_core.
module psc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input psc_pkg::psc_out_t out_data_o
);
  import psc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output slot");

  a_hit_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.hit_body &&
                      (out_data_o.hit_end_a || out_data_o.hit_end_b)))
    else $error("body hit together with endpoint hit");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result beat valid during reset");

endmodule

bind particle_segment_collision_response_core psc_checker u_psc_checker (.*);
